[design/mws_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants for the waveform synthesizer
// Register map, wave codes and the quarter-wave sine entry generator.
// ----------------------------------------------------------------------------
package mws_pkg;

	localparam int NUM_REGS   = 6;
	localparam int REG_IDX_W  = 3;
	localparam int AMP_BITS   = 15;
	localparam int ENTRY_BITS = 15;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [2:0]           wave_t;

	localparam reg_idx_t REG_WAVE_SELECT    = 3'd0;
	localparam reg_idx_t REG_AMPLITUDE      = 3'd1;
	localparam reg_idx_t REG_PHASE_STEP     = 3'd2;
	localparam reg_idx_t REG_PHASE_SHIFT    = 3'd3;
	localparam reg_idx_t REG_DUTY_THRESHOLD = 3'd4;
	localparam reg_idx_t REG_START_PHASE    = 3'd5;

	localparam wave_t WAVE_SINE     = 3'd0;
	localparam wave_t WAVE_SQUARE   = 3'd1;
	localparam wave_t WAVE_TRIANGLE = 3'd2;
	localparam wave_t WAVE_RISE     = 3'd3;
	localparam wave_t WAVE_FALL     = 3'd4;

	localparam wave_t               WAVE_RESET      = WAVE_SINE;
	localparam logic [AMP_BITS-1:0] AMPLITUDE_RESET = 15'd16384;
	localparam logic [31:0]         STEP_RESET      = 32'd4294967;
	localparam logic [31:0]         SHIFT_RESET     = 32'd0;
	localparam logic [31:0]         DUTY_RESET      = 32'h8000_0000;
	localparam logic [31:0]         START_RESET     = 32'd0;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] UNIT_MAX    = 64'd32767;

	// Quarter-wave entry at the center of bin idx, Q30 Taylor series to x^13.
	// Only evaluated at elaboration.
	function automatic logic [ENTRY_BITS-1:0] sine_entry(input int unsigned idx,
			input int unsigned addr_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] s;
		logic [63:0] v;
		x  = (HALF_PI_Q30 * (64'(idx) * 64'd2 + 64'd1)) >> (addr_bits + 1);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		d  = ((x2 * t) >> 30) / 64'd156;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		d  = ((x2 * t) >> 30) / 64'd110;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		d  = ((x2 * t) >> 30) / 64'd72;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		d  = ((x2 * t) >> 30) / 64'd42;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		d  = ((x2 * t) >> 30) / 64'd20;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		d  = ((x2 * t) >> 30) / 64'd6;
		t  = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
		s  = (x * t) >> 30;
		v  = (s * UNIT_MAX + (Q30_ONE >> 1)) >> 30;
		if (v > UNIT_MAX) begin
			v = UNIT_MAX;
		end
		return ENTRY_BITS'(v);
	endfunction

endpackage
`default_nettype wire

[design/mws_sine_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mws_sine_rom: quarter-wave sine table
// Constant table filled at elaboration, one registered read port.
// ----------------------------------------------------------------------------
module mws_sine_rom #(
	parameter int ADDR_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [ADDR_BITS-1:0]            addr,
	output logic      [mws_pkg::ENTRY_BITS-1:0]  data
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [mws_pkg::ENTRY_BITS-1:0] rom_mem [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_fill
		assign rom_mem[g] = mws_pkg::sine_entry(int'(g), ADDR_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data <= rom_mem[addr];
		end
	end

endmodule
`default_nettype wire

[design/multi_waveform_synthesizer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_synthesizer_unit: phase-accumulator waveform generator
// Sine, square, triangle and rising/falling sawtooth, signed Q15 samples.
// ----------------------------------------------------------------------------
// Each input beat produces one output beat holding the sample for the current
// accumulator phase and that phase; advance=1 then steps the phase. The block
// is a four-stage pipeline (input capture, sine table read, amplitude
// multiply, rounding/saturation into the output register) and takes one beat
// per cycle as long as out_stall is low; a result passes through the capture,
// table-read and multiply registers into the output register.
// Writing start_phase also loads the accumulator.
// Registers sit at byte offsets 0, 4, 8, 12, 16, 20 in the order wave_select,
// amplitude, phase_step, phase_shift, duty_threshold, start_phase, and should
// be written only while no beat is in flight.
module multi_waveform_synthesizer_unit #(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [4:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   advance,
	// output channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample,
	output logic      [31:0]            phase_now
);

	localparam int P         = PHASE_BITS;
	localparam int UP_SHIFT  = (P >= 32) ? (P - 32) : 0;
	localparam int DN_SHIFT  = (P < 32) ? (32 - P) : 0;
	localparam int FRAC_BITS = P + 1;
	localparam int PROD_BITS = mws_pkg::AMP_BITS + FRAC_BITS;
	localparam int SAT_BITS  = 26;

	localparam logic [FRAC_BITS-1:0] FULL      = FRAC_BITS'(1) << P;
	localparam logic [PROD_BITS-1:0] RND_SINE  = PROD_BITS'(1) << 14;
	localparam logic [PROD_BITS-1:0] RND_FRAC  = PROD_BITS'(1) << (P - 1);
	localparam logic signed [SAT_BITS-1:0] SAT_HI =
		SAT_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_HI - SAT_BITS'(1);

	function automatic logic [P-1:0] align_in(input logic [31:0] v);
		return P'((64'(v) << UP_SHIFT) >> DN_SHIFT);
	endfunction

	function automatic logic [31:0] align_out(input logic [P-1:0] p);
		return 32'((64'(p) >> UP_SHIFT) << DN_SHIFT);
	endfunction

	// ---------------- configuration ----------------
	mws_pkg::wave_t                  wave_select_q;
	logic [mws_pkg::AMP_BITS-1:0]    amplitude_q;
	logic [31:0]                     phase_step_q;
	logic [31:0]                     phase_shift_q;
	logic [31:0]                     duty_threshold_q;
	logic [31:0]                     start_phase_q;
	logic [P-1:0]                    acc_q;

	mws_pkg::reg_idx_t reg_idx;
	logic              cfg_we;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			mws_pkg::REG_WAVE_SELECT:    prdata = 32'(wave_select_q);
			mws_pkg::REG_AMPLITUDE:      prdata = 32'(amplitude_q);
			mws_pkg::REG_PHASE_STEP:     prdata = phase_step_q;
			mws_pkg::REG_PHASE_SHIFT:    prdata = phase_shift_q;
			mws_pkg::REG_DUTY_THRESHOLD: prdata = duty_threshold_q;
			mws_pkg::REG_START_PHASE:    prdata = start_phase_q;
			default:                     prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	logic en1, en2, en3, en_out, accept;

	assign en_out    = !out_vld_q || !out_stall;
	assign en3       = !vld_s3 || en_out;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign in_stall  = !en1;
	assign accept    = in_valid && en1;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q    <= mws_pkg::WAVE_RESET;
			amplitude_q      <= mws_pkg::AMPLITUDE_RESET;
			phase_step_q     <= mws_pkg::STEP_RESET;
			phase_shift_q    <= mws_pkg::SHIFT_RESET;
			duty_threshold_q <= mws_pkg::DUTY_RESET;
			start_phase_q    <= mws_pkg::START_RESET;
			acc_q            <= '0;
			vld_s1           <= 1'b0;
			vld_s2           <= 1'b0;
			vld_s3           <= 1'b0;
			out_vld_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx)
					mws_pkg::REG_WAVE_SELECT:    wave_select_q    <= pwdata[2:0];
					mws_pkg::REG_AMPLITUDE:      amplitude_q      <= pwdata[14:0];
					mws_pkg::REG_PHASE_STEP:     phase_step_q     <= pwdata;
					mws_pkg::REG_PHASE_SHIFT:    phase_shift_q    <= pwdata;
					mws_pkg::REG_DUTY_THRESHOLD: duty_threshold_q <= pwdata;
					mws_pkg::REG_START_PHASE:    start_phase_q    <= pwdata;
					default: ;
				endcase
			end
			if (cfg_we && reg_idx == mws_pkg::REG_START_PHASE) begin
				acc_q <= align_in(pwdata);
			end else if (accept && advance) begin
				acc_q <= acc_q + align_in(phase_step_q);
			end
			if (en1) begin
				vld_s1 <= accept;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
			if (en_out) begin
				out_vld_q <= vld_s3;
			end
		end
	end

	// ---------------- stage 1: phase capture ----------------
	logic [P-1:0] ph_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ph_s1 <= acc_q;
		end
	end

	// ---------------- stage 2: table read, wave operand ----------------
	logic [P-1:0]               sine_ph;
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] tbl_idx;
	logic [TABLE_ADDR_BITS-1:0] rom_addr;
	logic [FRAC_BITS-1:0]       two_ph;
	logic [FRAC_BITS-1:0]       frac_c;
	logic [mws_pkg::ENTRY_BITS-1:0] rom_data;

	logic [P-1:0]         ph_s2;
	logic [FRAC_BITS-1:0] frac_s2;
	logic                 is_sine_s2;
	logic                 neg_s2;

	assign sine_ph  = ph_s1 + align_in(phase_shift_q);
	assign quad     = sine_ph[P-1 -: 2];
	assign tbl_idx  = sine_ph[P-3 -: TABLE_ADDR_BITS];
	// odd quadrants run the table backwards
	assign rom_addr = quad[0] ? ~tbl_idx : tbl_idx;
	assign two_ph   = {ph_s1, 1'b0};

	always_comb begin
		unique case (wave_select_q)
			mws_pkg::WAVE_SQUARE:   frac_c = (ph_s1 < align_in(duty_threshold_q)) ? FULL : '0;
			mws_pkg::WAVE_TRIANGLE: frac_c = (two_ph >= FULL) ? (two_ph - FULL) : (FULL - two_ph);
			mws_pkg::WAVE_RISE:     frac_c = {1'b0, ph_s1};
			mws_pkg::WAVE_FALL:     frac_c = FULL - {1'b0, ph_s1};
			default:                frac_c = '0;
		endcase
	end

	mws_sine_rom #(
		.ADDR_BITS(TABLE_ADDR_BITS)
	) u_rom (
		.clk (clk),
		.en  (en2),
		.addr(rom_addr),
		.data(rom_data)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			ph_s2      <= ph_s1;
			frac_s2    <= frac_c;
			is_sine_s2 <= (wave_select_q == mws_pkg::WAVE_SINE);
			neg_s2     <= (wave_select_q == mws_pkg::WAVE_SINE) && quad[1];
		end
	end

	// ---------------- stage 3: amplitude multiply ----------------
	logic [FRAC_BITS-1:0] opb;
	logic [PROD_BITS-1:0] prod_c;

	logic [P-1:0]         ph_s3;
	logic [PROD_BITS-1:0] prod_s3;
	logic                 is_sine_s3;
	logic                 neg_s3;

	assign opb    = is_sine_s2 ? FRAC_BITS'(rom_data) : frac_s2;
	assign prod_c = PROD_BITS'(amplitude_q) * PROD_BITS'(opb);

	always_ff @(posedge clk) begin
		if (en3) begin
			ph_s3      <= ph_s2;
			prod_s3    <= prod_c;
			is_sine_s3 <= is_sine_s2;
			neg_s3     <= neg_s2;
		end
	end

	// ---------------- output: round, sign, saturate ----------------
	logic [PROD_BITS-1:0]          sum_sine, sum_frac;
	logic [mws_pkg::AMP_BITS-1:0]  mag;
	logic signed [SAT_BITS-1:0]    mag_ext, sval, sat;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [31:0]                   phase_now_q;

	assign sum_sine = prod_s3 + RND_SINE;
	assign sum_frac = prod_s3 + RND_FRAC;
	assign mag      = is_sine_s3 ? mws_pkg::AMP_BITS'(sum_sine >> 15)
	                             : mws_pkg::AMP_BITS'(sum_frac >> P);
	assign mag_ext  = SAT_BITS'(mag);
	assign sval     = neg_s3 ? -mag_ext : mag_ext;

	always_comb begin
		priority if (sval > SAT_HI) begin
			sat = SAT_HI;
		end else if (sval < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = sval;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sample_q    <= sat[SAMPLE_BITS-1:0];
			phase_now_q <= align_out(ph_s3);
		end
	end

	assign sample    = sample_q;
	assign phase_now = phase_now_q;

endmodule
`default_nettype wire

[verif/tb_multi_waveform_synthesizer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_synthesizer_unit: self-checking bench for the synthesizer
// Drives ticks through the valid/stall input channel and sets up waves over
// the APB port. A scoreboard predicts each sample and phase and checks the
// output beats in order.
// ----------------------------------------------------------------------------
module tb_multi_waveform_synthesizer_unit;

	localparam int                CLK_HALF     = 6;
	localparam int                RESET_CYCLES = 11;
	localparam int                SETTLE       = 8;
	localparam int                STALL_LIMIT  = 1000;
	localparam int                RANDOM_BEATS = 1550;
	localparam int                TABLE_BITS   = 10;
	localparam mws_pkg::reg_idx_t REG_VOID_A   = 3'd6;
	localparam mws_pkg::reg_idx_t REG_VOID_B   = 3'd7;
	localparam mws_pkg::wave_t    WAVE_TOP     = 3'd7;

	typedef struct {
		logic signed [15:0] level;
		logic [31:0]        phase;
	} tone_t;

	class tone_scoreboard;
		mws_pkg::wave_t wave_sel;
		logic [14:0]    amp;
		logic [31:0]    step;
		logic [31:0]    shift;
		logic [31:0]    duty;
		logic [31:0]    accum;
		logic [14:0]    quarter_sine [1 << TABLE_BITS];
		tone_t          pending_tones [$];
		int             failures;

		function new();
			for (int n = 0; n < (1 << TABLE_BITS); n++) begin
				quarter_sine[n] = quarter_entry(n);
			end
			wave_sel = mws_pkg::WAVE_RESET;
			amp      = mws_pkg::AMPLITUDE_RESET;
			step     = mws_pkg::STEP_RESET;
			shift    = mws_pkg::SHIFT_RESET;
			duty     = mws_pkg::DUTY_RESET;
			accum    = '0;
			failures = 0;
		endfunction

		// sine at the center of bin n, Taylor series in Q30, rounded to Q15
		function logic [14:0] quarter_entry(int n);
			logic [63:0] x;
			logic [63:0] x2;
			logic [63:0] t;
			logic [63:0] d;
			logic [63:0] s;
			logic [63:0] v;
			int          k;
			x  = (mws_pkg::HALF_PI_Q30 * (64'(n) * 2 + 1)) >> (TABLE_BITS + 1);
			x2 = (x * x) >> 30;
			t  = mws_pkg::Q30_ONE;
			for (k = 13; k >= 3; k -= 2) begin
				d = ((x2 * t) >> 30) / 64'(k * (k - 1));
				t = (d >= mws_pkg::Q30_ONE) ? 64'd0 : mws_pkg::Q30_ONE - d;
			end
			s = (x * t) >> 30;
			v = (s * mws_pkg::UNIT_MAX + (mws_pkg::Q30_ONE >> 1)) >> 30;
			if (v > mws_pkg::UNIT_MAX) begin
				v = mws_pkg::UNIT_MAX;
			end
			return v[14:0];
		endfunction

		function logic signed [15:0] scaled(logic [32:0] frac);
			logic [63:0] prod;
			prod = (64'(amp) * 64'(frac) + 64'h8000_0000) >> 32;
			return $signed(prod[15:0]);
		endfunction

		function logic signed [15:0] tone_level(logic [31:0] ph);
			logic [31:0] p;
			logic [9:0]  ix;
			logic [63:0] mag;
			logic [32:0] twice;
			logic [32:0] tri_span;
			case (wave_sel)
				mws_pkg::WAVE_SINE: begin
					p  = ph + shift;
					ix = p[29:20];
					if (p[30]) begin
						ix = ~ix;
					end
					mag = (64'(amp) * 64'(quarter_sine[ix]) + 64'd16384) >> 15;
					return p[31] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
				end
				mws_pkg::WAVE_SQUARE: begin
					return (ph < duty) ? $signed({1'b0, amp}) : 16'sd0;
				end
				mws_pkg::WAVE_TRIANGLE: begin
					twice    = {ph, 1'b0};
					tri_span = (twice >= 33'h1_0000_0000) ? twice - 33'h1_0000_0000
						: 33'h1_0000_0000 - twice;
					return scaled(tri_span);
				end
				mws_pkg::WAVE_RISE: begin
					return scaled({1'b0, ph});
				end
				mws_pkg::WAVE_FALL: begin
					return scaled(33'h1_0000_0000 - {1'b0, ph});
				end
				default: begin
					return 16'sd0;
				end
			endcase
		endfunction

		function void set_reg(mws_pkg::reg_idx_t idx, logic [31:0] data);
			case (idx)
				mws_pkg::REG_WAVE_SELECT:    wave_sel = data[2:0];
				mws_pkg::REG_AMPLITUDE:      amp = data[14:0];
				mws_pkg::REG_PHASE_STEP:     step = data;
				mws_pkg::REG_PHASE_SHIFT:    shift = data;
				mws_pkg::REG_DUTY_THRESHOLD: duty = data;
				mws_pkg::REG_START_PHASE:    accum = data;
				default: ;
			endcase
		endfunction

		function void note_tick(logic adv);
			tone_t t;
			t.level = tone_level(accum);
			t.phase = accum;
			pending_tones.push_back(t);
			if (adv) begin
				accum = accum + step;
			end
		endfunction

		function void check_tick(logic signed [15:0] level, logic [31:0] phase);
			tone_t t;
			if (pending_tones.size() == 0) begin
				$error("unexpected output beat: sample %0d phase %h", level, phase);
				failures++;
				return;
			end
			t = pending_tones.pop_front();
			if (level !== t.level) begin
				$error("sample: expected %0d, got %0d", t.level, level);
				failures++;
			end
			if (phase !== t.phase) begin
				$error("phase_now: expected %h, got %h", t.phase, phase);
				failures++;
			end
		endfunction

		function int pending();
			return pending_tones.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               advance;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] sample;
	logic [31:0]        phase_now;

	bit             calm;
	int             quiet_cycles;
	tone_scoreboard sb = new();

	multi_waveform_synthesizer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.advance  (advance),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample   (sample),
		.phase_now(phase_now)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_tick(advance);
			end
			if (out_valid && !out_stall) begin
				sb.check_tick(sample, phase_now);
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= arst_n && !calm && ($urandom_range(0, 99) < 8);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at a falling edge with the bus idle
	task automatic reg_write(input mws_pkg::reg_idx_t idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_beat(input logic adv);
		in_valid <= 1'b1;
		advance  <= adv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// hold off the sender until every result is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic shuffle_setup();
		logic [31:0] v;
		if ($urandom_range(0, 3) != 0) begin
			v = $urandom;
			v[2:0] = ($urandom_range(0, 9) < 8)
				? 3'($urandom_range(mws_pkg::WAVE_SINE, mws_pkg::WAVE_FALL))
				: 3'($urandom_range(mws_pkg::WAVE_FALL + 1, WAVE_TOP));
			reg_write(mws_pkg::REG_WAVE_SELECT, v);
		end
		if ($urandom_range(0, 1) != 0) begin
			v = $urandom;
			case ($urandom_range(0, 5))
				0: v[14:0] = '0;
				1: v[14:0] = '1;
				default: ;
			endcase
			reg_write(mws_pkg::REG_AMPLITUDE, v);
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 5))
				0: v = '0;
				1: v = '1;
				2: v = $urandom_range(1, 1 << 20);
				default: v = $urandom;
			endcase
			reg_write(mws_pkg::REG_PHASE_STEP, v);
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			reg_write(mws_pkg::REG_PHASE_SHIFT, v);
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			reg_write(mws_pkg::REG_DUTY_THRESHOLD, v);
		end
		if ($urandom_range(0, 1) != 0) begin
			case ($urandom_range(0, 4))
				0: v = '0;
				1: v = '1;
				default: v = $urandom;
			endcase
			reg_write(mws_pkg::REG_START_PHASE, v);
		end
		if ($urandom_range(0, 7) == 0) begin
			reg_write(($urandom_range(0, 1) != 0) ? REG_VOID_A : REG_VOID_B, $urandom);
		end
	endtask

	initial begin
		int run_len;
		int beats_sent;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		advance  = 1'b0;
		calm     = 1'b0;
		beats_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: sine, half scale, slow step
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b1);
		drain();

		// sine in quarter steps, full scale; shift of -1 lands on quadrant edges
		reg_write(mws_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
		reg_write(mws_pkg::REG_PHASE_STEP, 32'h4000_0000);
		reg_write(mws_pkg::REG_PHASE_SHIFT, 32'hFFFF_FFFF);
		reg_write(mws_pkg::REG_START_PHASE, 32'h0);
		repeat (5) send_beat(1'b1);
		drain();

		reg_write(mws_pkg::REG_WAVE_SELECT, 32'(mws_pkg::WAVE_SQUARE));
		reg_write(mws_pkg::REG_DUTY_THRESHOLD, 32'h8000_0000);
		reg_write(mws_pkg::REG_PHASE_STEP, 32'h7FFF_FFFF);
		reg_write(mws_pkg::REG_START_PHASE, 32'h0);
		repeat (3) send_beat(1'b1);
		drain();

		reg_write(mws_pkg::REG_WAVE_SELECT, 32'(mws_pkg::WAVE_TRIANGLE));
		reg_write(mws_pkg::REG_PHASE_STEP, 32'h8000_0000);
		reg_write(mws_pkg::REG_START_PHASE, 32'h0);
		repeat (3) send_beat(1'b1);
		drain();

		// saws across the wrap point
		reg_write(mws_pkg::REG_WAVE_SELECT, 32'(mws_pkg::WAVE_RISE));
		reg_write(mws_pkg::REG_PHASE_STEP, 32'h1);
		reg_write(mws_pkg::REG_START_PHASE, 32'hFFFF_FFFF);
		repeat (2) send_beat(1'b1);
		drain();

		reg_write(mws_pkg::REG_WAVE_SELECT, 32'(mws_pkg::WAVE_FALL));
		reg_write(mws_pkg::REG_START_PHASE, 32'hFFFF_FFFF);
		repeat (2) send_beat(1'b1);
		drain();

		// unused wave code, excess bits dropped, writes past the map ignored
		reg_write(mws_pkg::REG_WAVE_SELECT, 32'hFFFF_FFFF);
		reg_write(mws_pkg::REG_AMPLITUDE, 32'hFFFF_0000);
		reg_write(REG_VOID_A, 32'hFFFF_FFFF);
		reg_write(REG_VOID_B, 32'h0);
		send_beat(1'b0);
		send_beat(1'b1);
		drain();

		while (beats_sent < RANDOM_BEATS) begin
			calm = (beats_sent >= 500 && beats_sent < 800);
			shuffle_setup();
			run_len = $urandom_range(20, 90);
			repeat (run_len) begin
				if (!calm && $urandom_range(0, 99) < 8) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 3)) @(negedge clk);
				end
				send_beat($urandom_range(0, 3) != 0);
				beats_sent++;
			end
			drain();
		end

		if (sb.failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sim.f]
design/mws_pkg.sv
design/mws_sine_rom.sv
design/multi_waveform_synthesizer_unit.sv
verif/tb_multi_waveform_synthesizer_unit.sv
